// ===== sv/ple_pkg.sv =====
// Package of shared constants, types and the channel linearization table.
package ple_pkg;

  localparam int PALETTE_ENTRIES = 256;

  localparam int LIN_W = 31;
  localparam int JOB_W = 54;
  localparam int QUO_W = 31;
  localparam int LIGHT_W = 15;
  localparam int IDX_W = 8;
  localparam int CHAN_W = 8;

  localparam int NY_W = 47;
  localparam int PART_W = 24;
  localparam int PART_STEPS = 4;
  localparam int ACC_W = 96;
  localparam int Y_SHIFT = 64;
  localparam int NL_W = 19;
  localparam int L_SHIFT = 26;

  localparam logic [21:0] W_RED = 22'd2126729;
  localparam logic [22:0] W_GREEN = 23'd7151522;
  localparam logic [19:0] W_BLUE = 20'd721750;
  localparam logic [22:0] Y_BIAS = 23'd5000000;

  localparam logic [47:0] RECIP_Y = 48'd236118324143483;
  localparam logic [19:0] RECIP_L = 20'd536871;
  localparam logic [QUO_W-1:0] CUBE_KNEE = 31'd9509058;
  localparam logic [19:0] LIN_SLOPE = 20'd903292;
  localparam logic [30:0] LIN_BIAS = 31'd2097152000;
  localparam logic [14:0] L_GAIN = 15'd29696;
  localparam logic [46:0] L_ROUND = 47'd536870912;
  localparam logic [16:0] L_OFFSET = 17'd4096;
  localparam logic [LIGHT_W-1:0] L_MAX = 15'd25600;

  typedef logic [LIN_W-1:0] lin_tab_t [0:255];

  typedef struct packed {
    logic [JOB_W-1:0] wsum;
    logic             last;
  } ple_job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_Y,
    ST_BRANCH,
    ST_ROOT_SQ,
    ST_ROOT_CU,
    ST_DIV_L,
    ST_SCALE,
    ST_EMIT
  } ple_state_t;

  function automatic longint unsigned fifth_trunc(longint unsigned t);
    longint unsigned p;
    p = t;
    for (int k = 0; k < 4; k++) begin
      p = (p * t) >> 30;
    end
    return p;
  endfunction

  function automatic lin_tab_t build_lin_table();
    lin_tab_t        tab;
    longint unsigned v;
    longint unsigned s;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    for (int i = 0; i < 256; i++) begin
      v = longint'(i);
      if (v <= 64'd10) begin
        p = (((v * 64'd100) << 30) + 64'd164730) / 64'd329460;
      end else begin
        s = (((64'd1000 * v + 64'd14025) << 30) + 64'd134512) / 64'd269025;
        lo = 64'd0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
          mid = lo + (hi - lo + 64'd1) / 64'd2;
          if (fifth_trunc(mid) <= s) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
        p = lo;
        for (int k = 0; k < 11; k++) begin
          p = (p * lo + (64'd1 << 29)) >> 30;
        end
      end
      tab[i] = p[LIN_W-1:0];
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TABLE = build_lin_table();

endpackage

// ===== sv/ple_if.sv =====
// Channel interfaces for palette entries and lightness results.
interface ple_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_entry;

  modport source (output valid, red, green, blue, last_entry, input ready);
  modport sink (input valid, red, green, blue, last_entry, output ready);
endinterface

interface ple_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] lightness;
  logic [7:0]  darkest_index;
  logic [7:0]  lightest_index;
  logic        palette_done;

  modport source (output valid, lightness, darkest_index, lightest_index, palette_done,
                  input ready);
  modport sink (input valid, lightness, darkest_index, lightest_index, palette_done,
                output ready);
endinterface

// ===== sv/ple_front.sv =====
// Front pipeline: channel linearization lookup and weighted luminance sum.
module ple_front
  import ple_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ple_in_if.sink     in_ch,
  output logic       push,
  output ple_job_t   push_job,
  input  logic       q_full
);

  logic             advance;
  logic             a_valid_r;
  logic [LIN_W-1:0] a_lin_red_r;
  logic [LIN_W-1:0] a_lin_green_r;
  logic [LIN_W-1:0] a_lin_blue_r;
  logic             a_last_r;
  logic             b_valid_r;
  logic [52:0]      b_prod_red_r;
  logic [53:0]      b_prod_green_r;
  logic [50:0]      b_prod_blue_r;
  logic             b_last_r;

  assign advance = !b_valid_r || !q_full;
  assign in_ch.ready = advance;
  assign push = b_valid_r && !q_full;

  assign push_job.wsum = JOB_W'(b_prod_red_r) + b_prod_green_r + JOB_W'(b_prod_blue_r)
                         + JOB_W'(Y_BIAS);
  assign push_job.last = b_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r <= in_ch.valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_lin_red_r    <= LIN_TABLE[in_ch.red];
      a_lin_green_r  <= LIN_TABLE[in_ch.green];
      a_lin_blue_r   <= LIN_TABLE[in_ch.blue];
      a_last_r       <= in_ch.last_entry;
      b_prod_red_r   <= 53'(W_RED) * 53'(a_lin_red_r);
      b_prod_green_r <= 54'(W_GREEN) * 54'(a_lin_green_r);
      b_prod_blue_r  <= 51'(W_BLUE) * 51'(a_lin_blue_r);
      b_last_r       <= a_last_r;
    end
  end

endmodule

// ===== sv/ple_queue.sv =====
// Two-entry request queue between the front pipeline and the back sequencer.
module ple_queue
  import ple_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ple_job_t push_job,
  output logic     full,
  input  logic     pop,
  output ple_job_t pop_job,
  output logic     empty
);

  ple_job_t   slots_r [0:1];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full = count_r == 2'd2;
  assign empty = count_r == 2'd0;
  assign pop_job = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== sv/ple_back.sv =====
// Back sequencer: reciprocal division, bitwise cube root, L* scaling and extremes tracking.
module ple_back
  import ple_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  ple_job_t q_job,
  output logic     pop,
  ple_out_if.source out_ch
);

  typedef struct packed {
    logic load_y;
    logic load_l;
    logic y_step;
    logic l_step;
    logic root_init;
    logic root_sq;
    logic root_cu;
    logic scale;
    logic emit;
  } ple_ctrl_t;

  ple_state_t        state_r;
  ple_state_t        state_nxt;
  ple_ctrl_t         ctrl;
  logic              emit_go;

  logic [NY_W-1:0]   ny_r;
  logic [ACC_W-1:0]  acc_r;
  logic [NL_W-1:0]   nl_r;
  logic [QUO_W-1:0]  quo_r;
  logic [4:0]        cnt_r;
  logic              last_r;
  logic              cube_path_r;

  logic [QUO_W-1:0]  root_r;
  logic [QUO_W-1:0]  cand_r;
  logic [31:0]       sq_r;
  logic [LIGHT_W-1:0] l_r;

  logic [PART_W-1:0] ny_part;
  logic [PART_W-1:0] recip_part;
  logic [47:0]       part_prod;
  logic [ACC_W-1:0]  acc_add;
  logic [ACC_W-1:0]  acc_sum;
  logic [38:0]       l_prod;
  logic [QUO_W-1:0]  cand;
  logic [61:0]       sq_full;
  logic [62:0]       cube_full;
  logic [32:0]       cube;
  logic [43:0]       lin_num;
  logic [46:0]       scaled;
  logic [16:0]       l_raw;
  logic [16:0]       l_sub;
  logic [LIGHT_W-1:0] l_cube;
  logic [LIGHT_W-1:0] l_lin;

  logic [IDX_W-1:0]  entry_cnt_r;
  logic              first_r;
  logic [LIGHT_W-1:0] dark_val_r;
  logic [LIGHT_W-1:0] light_val_r;
  logic [IDX_W-1:0]  dark_slot_r;
  logic [IDX_W-1:0]  light_slot_r;
  logic              take_dark;
  logic              take_light;
  logic              done;

  logic              out_valid_r;
  logic [LIGHT_W-1:0] out_light_r;
  logic [IDX_W-1:0]  out_dark_r;
  logic [IDX_W-1:0]  out_lightest_r;
  logic              out_done_r;

  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (cnt_r == 5'd0) begin
          state_nxt = ST_BRANCH;
        end
      end
      ST_BRANCH: begin
        state_nxt = (quo_r >= CUBE_KNEE) ? ST_ROOT_SQ : ST_DIV_L;
      end
      ST_ROOT_SQ: begin
        state_nxt = ST_ROOT_CU;
      end
      ST_ROOT_CU: begin
        state_nxt = (cnt_r == 5'd0) ? ST_SCALE : ST_ROOT_SQ;
      end
      ST_DIV_L: begin
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      ST_IDLE: begin
        ctrl.load_y = !q_empty;
      end
      ST_DIV_Y: begin
        ctrl.y_step = 1'b1;
      end
      ST_BRANCH: begin
        ctrl.root_init = quo_r >= CUBE_KNEE;
        ctrl.load_l = quo_r < CUBE_KNEE;
      end
      ST_ROOT_SQ: begin
        ctrl.root_sq = 1'b1;
      end
      ST_ROOT_CU: begin
        ctrl.root_cu = 1'b1;
      end
      ST_DIV_L: begin
        ctrl.l_step = 1'b1;
      end
      ST_SCALE: begin
        ctrl.scale = 1'b1;
      end
      ST_EMIT: begin
        ctrl.emit = emit_go;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  assign pop = ctrl.load_y;

  assign ny_part = cnt_r[1] ? PART_W'(ny_r[NY_W-1:PART_W]) : ny_r[PART_W-1:0];
  assign recip_part = cnt_r[0] ? RECIP_Y[2*PART_W-1:PART_W] : RECIP_Y[PART_W-1:0];
  assign part_prod = 48'(ny_part) * 48'(recip_part);

  always_comb begin
    case (cnt_r[1:0])
      2'b00: acc_add = ACC_W'(part_prod);
      2'b11: acc_add = ACC_W'(part_prod) << (2 * PART_W);
      default: acc_add = ACC_W'(part_prod) << PART_W;
    endcase
  end

  assign acc_sum = acc_r + acc_add;
  assign l_prod = 39'(nl_r) * 39'(RECIP_L);

  assign cand = root_r | (QUO_W'(1) << cnt_r);
  assign sq_full = 62'(cand) * 62'(cand);
  assign cube_full = 63'(sq_r) * 63'(cand_r);
  assign cube = cube_full[62:30];

  assign lin_num = 44'(LIN_SLOPE) * 44'(quo_r) + 44'(LIN_BIAS);

  assign scaled = 47'(L_GAIN) * 47'(root_r) + L_ROUND;
  assign l_raw = scaled[46:30];
  assign l_sub = (l_raw > L_OFFSET) ? (l_raw - L_OFFSET) : 17'd0;
  assign l_cube = (l_sub > 17'(L_MAX)) ? L_MAX : l_sub[LIGHT_W-1:0];
  assign l_lin = (quo_r > QUO_W'(L_MAX)) ? L_MAX : quo_r[LIGHT_W-1:0];

  assign done = last_r || ({1'b0, entry_cnt_r} >= 9'(PALETTE_ENTRIES - 1));
  assign take_dark = first_r || (l_r < dark_val_r);
  assign take_light = first_r || (l_r > light_val_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      entry_cnt_r <= '0;
      first_r     <= 1'b1;
      dark_val_r  <= '0;
      light_val_r <= '0;
      dark_slot_r <= '0;
      light_slot_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (ctrl.emit) begin
        if (done) begin
          entry_cnt_r  <= '0;
          first_r      <= 1'b1;
          dark_val_r   <= '0;
          light_val_r  <= '0;
          dark_slot_r  <= '0;
          light_slot_r <= '0;
        end else begin
          entry_cnt_r <= entry_cnt_r + IDX_W'(1);
          first_r     <= 1'b0;
          if (take_dark) begin
            dark_val_r  <= l_r;
            dark_slot_r <= entry_cnt_r;
          end
          if (take_light) begin
            light_val_r  <= l_r;
            light_slot_r <= entry_cnt_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_y) begin
      ny_r        <= q_job.wsum[JOB_W-1:JOB_W-NY_W];
      acc_r       <= '0;
      cnt_r       <= 5'(PART_STEPS - 1);
      last_r      <= q_job.last;
      cube_path_r <= 1'b0;
    end else if (ctrl.load_l) begin
      nl_r <= lin_num[43:25];
    end else if (ctrl.y_step) begin
      acc_r <= acc_sum;
      quo_r <= acc_sum[Y_SHIFT +: QUO_W];
      cnt_r <= cnt_r - 5'd1;
    end else if (ctrl.l_step) begin
      quo_r <= QUO_W'(l_prod[38:L_SHIFT]);
    end else if (ctrl.root_init) begin
      root_r      <= '0;
      cnt_r       <= 5'(QUO_W - 1);
      cube_path_r <= 1'b1;
    end else if (ctrl.root_sq) begin
      cand_r <= cand;
      sq_r   <= sq_full[61:30];
    end else if (ctrl.root_cu) begin
      if (cube <= 33'(quo_r)) begin
        root_r <= cand_r;
      end
      cnt_r <= cnt_r - 5'd1;
    end else if (ctrl.scale) begin
      l_r <= cube_path_r ? l_cube : l_lin;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_light_r    <= l_r;
      out_dark_r     <= take_dark ? entry_cnt_r : dark_slot_r;
      out_lightest_r <= take_light ? entry_cnt_r : light_slot_r;
      out_done_r     <= done;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.lightness = out_light_r;
  assign out_ch.darkest_index = out_dark_r;
  assign out_ch.lightest_index = out_lightest_r;
  assign out_ch.palette_done = out_done_r;

endmodule

// ===== sv/palette_lightness_extremes.sv =====
// Top level: sRGB palette entry to CIELAB lightness with running darkest and lightest index.
// Each palette entry yields one result: its L* in 1/256 units (0 to 25600), the indices of
// the darkest and lightest entries seen so far in the palette (first index wins a tie), and
// a flag that marks the entry ending the palette, either by last_entry or by reaching index
// 255. The front pipeline looks up linear light per channel and forms the weighted luminance
// sum through a registered lookup and registered channel products, then hands it through a
// two-entry queue to the back sequencer. The back sequencer handles one entry at a time: a
// reciprocal multiplication built from four 24-by-24-bit partial products recovers Y, then
// either one more reciprocal multiplication (dark colors) or a bit-by-bit cube root, with a
// square step and a cube step per result bit, produces L*. The cube-root segment takes longer
// than the linear segment. A finished result waits in an output register while the next
// entry is already being worked on.
module palette_lightness_extremes
  import ple_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ple_in_if.sink    in_ch,
  ple_out_if.source out_ch
);

  logic     push;
  ple_job_t push_job;
  logic     q_full;
  logic     pop;
  ple_job_t pop_job;
  logic     q_empty;

  ple_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  ple_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  ple_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (pop_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
